/* sv/idafl_pkg.sv */
// Shared types and codes of the ID allocator with a FIFO free list.
`default_nettype none

package idafl_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] id_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] id_out;
    status_t    status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_FILL,
    S_FILL_END,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REMOVE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_RD_HEAD,
    DP_POP,
    DP_FRESH,
    DP_PUSH,
    DP_BUMP,
    DP_FILL,
    DP_FILL_END,
    DP_SCAN_RD,
    DP_SCAN_NEXT,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_REMOVE_END,
    DP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    count_zero;
    logic    fresh_avail;
    logic    id_range;
    logic    free_full;
    logic    id_eq;
    logic    id_gt;
    logic    gap_full;
    logic    fill_last;
    logic    match;
    logic    scan_last;
    logic    shift_last;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/id_allocator_fifo_free_list_core.sv */
// Top level of the ID allocator with a FIFO free list.
`default_nettype none

// Hands out unique IDs from 0 to ID_COUNT-1. A transaction is taken on the
// input channel at a rising edge where start is high and busy is low; the
// opcode selects allocate, free or mark-used. Every transaction yields exactly
// one result transaction: out_valid is high for one cycle with out_item, and
// the receiver cannot stall it, so no result ever waits.
// Paths through the controller: allocate from the fresh counter, free,
//   mark-used equal to the counter and every error are reported straight
//   from the decode state; allocate from the free list first reads the head,
//   since the single read port of the free-list memory has a registered output.
//   Mark-used above the counter makes one memory write per skipped ID. Mark-
//   used below the counter searches the list entry by entry and, when the ID
//   is found, shifts each entry behind it down one place and closes the gap;
//   with an empty list it is reported straight from the decode state.
// busy falls in the cycle that shows the result, so the next transaction can
// be taken at the edge that ends it, and one transaction is in work at a time.
// Synchronous reset (rst_n low) empties the free list and clears the fresh
// counter; the memory contents are not cleared because only entries inside
// the live window are ever read, so no clearing pass is needed.
module id_allocator_fifo_free_list_core import idafl_pkg::*; #(
  parameter int ID_COUNT = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences one transaction; it sees start and the datapath status (flags and latched opcode).
  idafl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath owns the free-list memory, all counters and the result register.
  idafl_dp #(
    .ID_COUNT (ID_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* sv/idafl_ctrl.sv */
// Sequencing state machine of the ID allocator.
`default_nettype none

module idafl_ctrl import idafl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = DP_NOP;
    cmd.status = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        unique case (stat.opcode)
          OP_ALLOC: begin
            priority if (!stat.count_zero) begin
              cmd.op    = DP_RD_HEAD;
              state_nxt = S_POP;
            end else if (stat.fresh_avail) begin
              cmd.op = DP_FRESH;
            end else begin
              cmd.op     = DP_REPORT;
              cmd.status = STAT_EXHAUSTED;
            end
          end
          OP_FREE: begin
            priority if (stat.id_range) begin
              cmd.op     = DP_REPORT;
              cmd.status = STAT_RANGE;
            end else if (stat.free_full) begin
              cmd.op     = DP_REPORT;
              cmd.status = STAT_FULL;
            end else begin
              cmd.op = DP_PUSH;
            end
          end
          OP_MARK: begin
            priority if (stat.id_range) begin
              cmd.op     = DP_REPORT;
              cmd.status = STAT_RANGE;
            end else if (stat.id_eq) begin
              cmd.op = DP_BUMP;
            end else if (stat.id_gt) begin
              if (stat.gap_full) begin
                cmd.op     = DP_REPORT;
                cmd.status = STAT_FULL;
              end else begin
                state_nxt = S_FILL;
              end
            end else if (stat.count_zero) begin
              cmd.op = DP_REPORT;
            end else begin
              cmd.op    = DP_SCAN_RD;
              state_nxt = S_SCAN_CMP;
            end
          end
          default: begin
            cmd.op = DP_REPORT;
          end
        endcase
      end
      S_POP: begin
        cmd.op    = DP_POP;
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        cmd.op = DP_FILL;
        if (stat.fill_last) begin
          state_nxt = S_FILL_END;
        end
      end
      S_FILL_END: begin
        cmd.op    = DP_FILL_END;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd.op    = DP_SCAN_RD;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (stat.match) begin
          state_nxt = stat.scan_last ? S_REMOVE : S_SHIFT_RD;
        end else if (stat.scan_last) begin
          // The ID is not in the list: accepted without any change.
          cmd.op    = DP_REPORT;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = DP_SCAN_NEXT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.op    = DP_SHIFT_RD;
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.op    = DP_SHIFT_WR;
        state_nxt = stat.shift_last ? S_REMOVE : S_SHIFT_RD;
      end
      S_REMOVE: begin
        cmd.op    = DP_REMOVE_END;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

/* sv/idafl_dp.sv */
// Datapath of the ID allocator: free-list memory, pointers, counters and result register.
`default_nettype none

module idafl_dp import idafl_pkg::*; #(
  parameter int ID_COUNT = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int AW  = $clog2(ID_COUNT);
  localparam int CW  = $clog2(ID_COUNT + 1);
  localparam int CW1 = CW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(ID_COUNT - 1);
  localparam logic [17:0]   N_WIDE    = 18'(ID_COUNT);

  logic [7:0] mem [ID_COUNT];

  opcode_t         op_r,     op_nxt;
  logic [7:0]      id_r,     id_nxt;
  logic [AW-1:0]   head_r,   head_nxt;
  logic [AW-1:0]   tail_r,   tail_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic [CW-1:0]   nf_r,     nf_nxt;
  logic [AW-1:0]   ptr_r,    ptr_nxt;
  logic [CW-1:0]   idx_r,    idx_nxt;
  logic [7:0]      fill_r,   fill_nxt;
  logic [7:0]      rd_data_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r,  out_item_nxt;

  logic [AW-1:0]   head_inc, tail_inc, tail_dec, ptr_inc;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      wr_data;
  logic [17:0]     id_wide, nf_wide, cnt_wide;

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST_SLOT : tail_r - 1'b1;
  assign ptr_inc  = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r;
    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = id_r;
    unique case (cmd.op)
      DP_RD_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
      DP_SCAN_RD: begin
        rd_en = 1'b1;
      end
      DP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_inc;
      end
      DP_PUSH: begin
        wr_en = 1'b1;
      end
      DP_FILL: begin
        wr_en   = 1'b1;
        wr_data = fill_r;
      end
      DP_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Register updates for each datapath command.
  always_comb begin
    op_nxt        = op_r;
    id_nxt        = id_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    nf_nxt        = nf_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (cmd.op)
      DP_LATCH: begin
        op_nxt   = in_item.opcode;
        id_nxt   = in_item.id_in;
        ptr_nxt  = head_r;
        idx_nxt  = '0;
        fill_nxt = 8'(nf_r);
      end
      DP_POP: begin
        head_nxt      = head_inc;
        count_nxt     = count_r - 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: rd_data_r, status: STAT_OK};
      end
      DP_FRESH: begin
        nf_nxt        = nf_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'(nf_r), status: STAT_OK};
      end
      DP_PUSH: begin
        tail_nxt      = tail_inc;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'd0, status: STAT_OK};
      end
      DP_BUMP: begin
        nf_nxt        = nf_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'd0, status: STAT_OK};
      end
      DP_FILL: begin
        tail_nxt  = tail_inc;
        count_nxt = count_r + 1'b1;
        fill_nxt  = fill_r + 8'd1;
      end
      DP_FILL_END: begin
        nf_nxt        = CW'(9'(id_r) + 9'd1);
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'd0, status: STAT_OK};
      end
      DP_SCAN_NEXT, DP_SHIFT_WR: begin
        ptr_nxt = ptr_inc;
        idx_nxt = idx_r + 1'b1;
      end
      DP_REMOVE_END: begin
        tail_nxt      = tail_dec;
        count_nxt     = count_r - 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'd0, status: STAT_OK};
      end
      DP_REPORT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{id_out: 8'd0, status: cmd.status};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    ptr_r      <= ptr_nxt;
    idx_r      <= idx_nxt;
    fill_r     <= fill_nxt;
    out_item_r <= out_item_nxt;
  end

  // Status toward the controller.
  assign id_wide  = 18'(id_r);
  assign nf_wide  = 18'(nf_r);
  assign cnt_wide = 18'(count_r);

  always_comb begin
    stat.opcode      = op_r;
    stat.count_zero  = (count_r == '0);
    stat.fresh_avail = (nf_wide != N_WIDE);
    stat.id_range    = (id_wide >= N_WIDE);
    stat.free_full   = (cnt_wide == N_WIDE);
    stat.id_eq       = (id_wide == nf_wide);
    stat.id_gt       = (id_wide > nf_wide);
    stat.gap_full    = ((cnt_wide + id_wide - nf_wide) > N_WIDE);
    stat.fill_last   = ((9'(fill_r) + 9'd1) == 9'(id_r));
    stat.match       = (rd_data_r == id_r);
    stat.scan_last   = ((CW1'(idx_r) + CW1'(1)) == CW1'(count_r));
    stat.shift_last  = ((CW1'(idx_r) + CW1'(2)) == CW1'(count_r));
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= ID_COUNT)
    else $error("free list count exceeds its capacity");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nf_r) <= ID_COUNT)
    else $error("fresh counter exceeds the ID range");

  a_tail_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (((32'(head_r) + 32'(count_r)) >= ID_COUNT) ?
      (32'(head_r) + 32'(count_r) - ID_COUNT) :
      (32'(head_r) + 32'(count_r))) == 32'(tail_r))
    else $error("tail pointer disagrees with head pointer and count");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire
